FILE: hdl/arp_cache_table_defines.svh
// Assertion macros shared by the address-resolution cache modules.
`ifndef ARP_CACHE_TABLE_DEFINES_SVH
`define ARP_CACHE_TABLE_DEFINES_SVH

// Checked only outside reset; needs clk and rst in scope.
`define ACT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ACT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/act_pkg.sv
// Types and constants shared by the address-resolution cache modules.
`timescale 1ns / 1ps

package act_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int OUT_IDX_W = 4;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W:0]   ENTRIES_C = (IDX_W + 1)'(ENTRIES);

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_SRCH = 2'd2;

  typedef struct packed {
    logic add;
    logic del;
    logic srch;
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [31:0]  ip;
    logic [47:0]  mac;
    logic [31:0]  now;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] ip;
    logic [31:0] stamp;
  } entry_t;

endpackage

FILE: hdl/act_req_if.sv
// Request channel of the address-resolution cache.
`timescale 1ns / 1ps

interface act_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] ip_addr;
  logic [47:0] mac_addr;
  logic [31:0] now_time;

  modport source (output valid, opcode, ip_addr, mac_addr, now_time, input ready);
  modport sink   (input valid, opcode, ip_addr, mac_addr, now_time, output ready);
endinterface

FILE: hdl/act_rsp_if.sv
// Response channel of the address-resolution cache.
`timescale 1ns / 1ps

interface act_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [3:0]  entry_index;
  logic [47:0] mac_out;
  logic        mac_conflict;

  modport source (output valid, found, entry_index, mac_out, mac_conflict, input ready);
  modport sink   (input valid, found, entry_index, mac_out, mac_conflict, output ready);
endinterface

FILE: hdl/act_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module act_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/act_front.sv
// Front end: accepts requests, decodes the opcode and queues commands.
`timescale 1ns / 1ps
`include "arp_cache_table_defines.svh"

module act_front (
  input  logic          clk,
  input  logic          rst,
  act_req_if.sink       req,
  output act_pkg::q_t   q,
  input  logic          pop
);

  act_pkg::cmd_t  slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  act_pkg::kind_t kind;
  logic           push;

  always_comb begin
    kind = '0;
    unique case (req.opcode)
      act_pkg::OP_ADD:  kind.add  = 1'b1;
      act_pkg::OP_DEL:  kind.del  = 1'b1;
      act_pkg::OP_SRCH: kind.srch = 1'b1;
      default:          kind = '0;
    endcase
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;

  assign q.valid = (count != 2'd0);
  assign q.cmd   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{kind: kind, ip: req.ip_addr, mac: req.mac_addr, now: req.now_time};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `ACT_ASSERT(a_pop_drains, (pop && !push) |=> (count == $past(count) - 2'd1), "queue count lost a pop")
  `ACT_ASSERT(a_count_range, count != 2'd3, "queue count beyond depth")
  `ACT_ASSERT_ALWAYS(a_reset_empty, rst |=> (count == 2'd0), "queue not empty after reset")

endmodule

FILE: hdl/act_engine.sv
// Back end: scans the entry store, applies the command and holds the response.
`timescale 1ns / 1ps
`include "arp_cache_table_defines.svh"

module act_engine (
  input  logic        clk,
  input  logic        rst,
  input  act_pkg::q_t q,
  output logic        pop,
  act_rsp_if.source   rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam int IW = act_pkg::IDX_W;

  logic [1:0]                state;
  act_pkg::cmd_t             cmd;
  logic [IW:0]               cnt;
  logic                      rd_vld;
  logic [IW-1:0]             eval_idx;
  logic [act_pkg::ENTRIES-1:0] valid;

  logic                      hit_found;
  logic [IW-1:0]             hit_idx;
  logic [47:0]               hit_mac;
  logic                      free_found;
  logic [IW-1:0]             free_idx;
  logic [31:0]               old_stamp;
  logic [IW-1:0]             old_idx;

  logic                      out_vld;
  logic                      out_found;
  logic [act_pkg::OUT_IDX_W-1:0] out_idx;
  logic [47:0]               out_mac;
  logic                      out_conflict;

  logic [$bits(act_pkg::entry_t)-1:0] rdata;
  act_pkg::entry_t           ent;
  logic                      used;
  logic                      go;
  logic [IW-1:0]             into;
  logic [IW-1:0]             res_idx;
  logic [IW+act_pkg::OUT_IDX_W-1:0] res_idx_ext;
  logic                      we;

  act_ram #(
    .WIDTH ($bits(act_pkg::entry_t)),
    .DEPTH (act_pkg::ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (into),
    .wdata ({cmd.mac, cmd.ip, cmd.now}),
    .raddr (cnt[IW-1:0]),
    .rdata (rdata)
  );

  // An entry never written since reset or since its delete reads as zero.
  assign ent  = valid[eval_idx] ? act_pkg::entry_t'(rdata) : '0;
  assign used = (ent.mac != 48'd0);

  assign pop  = (state == S_IDLE) && q.valid;
  assign go   = (state == S_FIN) && (!out_vld || rsp.ready);
  assign into = hit_found ? hit_idx : (free_found ? free_idx : old_idx);
  assign we   = go && cmd.kind.add;

  // An unused opcode reports index zero even when its address matches.
  assign res_idx     = cmd.kind.add ? into :
                       ((hit_found && (cmd.kind.del || cmd.kind.srch)) ? hit_idx : '0);
  assign res_idx_ext = {{act_pkg::OUT_IDX_W{1'b0}}, res_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      rd_vld <= 1'b0;
      valid  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt    <= '0;
          rd_vld <= 1'b0;
          if (q.valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_vld <= (cnt != act_pkg::ENTRIES_C);
          if (cnt != act_pkg::ENTRIES_C) begin
            cnt <= cnt + 1'b1;
          end
          if (rd_vld && eval_idx == act_pkg::LAST_IDX) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (go) begin
            state <= S_IDLE;
            if (cmd.kind.add) begin
              valid[into] <= 1'b1;
            end else if (cmd.kind.del && hit_found) begin
              valid[hit_idx] <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd        <= q.cmd;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end
    if (state == S_SCAN) begin
      eval_idx <= cnt[IW-1:0];
      if (rd_vld) begin
        if (!hit_found && used && ent.ip == cmd.ip) begin
          hit_found <= 1'b1;
          hit_idx   <= eval_idx;
          hit_mac   <= ent.mac;
        end
        if (!free_found && !used) begin
          free_found <= 1'b1;
          free_idx   <= eval_idx;
        end
        if (eval_idx == '0 || ent.stamp < old_stamp) begin
          old_stamp <= ent.stamp;
          old_idx   <= eval_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (go) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_found    <= cmd.kind.add || (hit_found && (cmd.kind.del || cmd.kind.srch));
      out_idx      <= res_idx_ext[act_pkg::OUT_IDX_W-1:0];
      out_mac      <= (cmd.kind.srch && hit_found) ? hit_mac : 48'd0;
      out_conflict <= cmd.kind.add && hit_found && (hit_mac != cmd.mac);
    end
  end

  assign rsp.valid        = out_vld;
  assign rsp.found        = out_found;
  assign rsp.entry_index  = out_idx;
  assign rsp.mac_out      = out_mac;
  assign rsp.mac_conflict = out_conflict;

  `ACT_ASSERT(a_load_from_fin, $rose(out_vld) |-> ($past(state) == S_FIN), "response loaded outside finish")
  `ACT_ASSERT(a_add_marks, we |=> valid[$past(into)], "added entry not marked valid")
  `ACT_ASSERT(a_del_clears, (go && cmd.kind.del && hit_found) |=> !valid[$past(hit_idx)], "deleted entry still valid")

endmodule

FILE: hdl/arp_cache_table.sv
// Top level of the address-resolution cache with oldest-entry replacement.
// Usage:
//   The req channel carries one command per transfer: opcode (add, delete,
//   search), IPv4 address, MAC address and time stamp. The rsp channel returns
//   exactly one result per command, in order: found flag, entry index, the
//   MAC on a search hit and a conflict flag for an add that changed a MAC.
//   A front end decodes commands into a two-deep queue; a back end then scans
//   every entry of the store, one RAM read per cycle, to find the first match,
//   the lowest free entry and the oldest stamp, and finally applies the command.
//   Each command occupies the back end for a whole scan of the store, set by
//   the single read port of the entry RAM; the back end takes no new command
//   until it has passed the result of the last one to its output register.
//   Up to two further requests are taken while one is being worked on.
//   Reset clears the per-entry valid bits at once, so every entry reads as
//   free straight away and no clearing pass is needed.
//   When the receiver stalls, the result waits in the output register; the
//   back end finishes its scan and then holds until that register is taken.

`timescale 1ns / 1ps

module arp_cache_table (
  input  logic      clk,
  input  logic      rst,
  act_req_if.sink   req,
  act_rsp_if.source rsp
);

  // Command queue between the decoding front end and the scanning back end.
  act_pkg::q_t q;
  logic        pop;

  act_front u_front (
    .clk (clk),
    .rst (rst),
    .req (req),
    .q   (q),
    .pop (pop)
  );

  act_engine u_engine (
    .clk (clk),
    .rst (rst),
    .q   (q),
    .pop (pop),
    .rsp (rsp)
  );

endmodule
